### sv/ife_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ife_pkg
// shared types and constants of the instantaneous frequency estimator
// ----------------------------------------------------------------------------
package ife_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int RATE_W       = 18;
    localparam int AMP_W        = 15;
    localparam int BAL_W        = 16;
    localparam int GAIN_W       = 16;
    localparam int FREQ_W       = 32;
    localparam int DIFF_W       = 17;
    localparam int SLOPE_W      = 37;
    localparam int HSQ_W        = 30;
    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 18;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);
    localparam logic [AMP_W-1:0]  AMP_RESET  = AMP_W'(32767);
    localparam logic [BAL_W-1:0]  BAL_RESET  = '0;
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE   = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_BALANCE     = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_GAIN  = CFG_INDEX_W'(3);

    localparam logic signed [SLOPE_W-1:0] SLOPE_BIAS = SLOPE_W'(655);

    typedef struct packed {
        logic [RATE_W-1:0] sample_rate;
        logic [AMP_W-1:0]  amplitude;
        logic [BAL_W-1:0]  balance;
        logic [GAIN_W-1:0] speed_gain;
    } cfg_t;

    typedef struct packed {
        logic signed [SLOPE_W-1:0] slope;
        logic [HSQ_W-1:0]          height_sq;
        logic                      out_of_range;
    } item_t;

endpackage

### sv/ife_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ife_front
// accepts samples, forms slope and squared height, flags out of range
// ----------------------------------------------------------------------------
module ife_front
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ife_pkg::cfg_t                        cfg,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [ife_pkg::SAMPLE_W-1:0]  sample,
    output logic                                 push,
    output ife_pkg::item_t                       push_item,
    input  logic                                 queue_full
);

    logic                                 s1_valid_reg;
    logic                                 s1_valid_next;
    logic signed [ife_pkg::SAMPLE_W-1:0]  s1_sample_reg;
    logic signed [ife_pkg::DIFF_W-1:0]    s1_diff_reg;
    logic signed [ife_pkg::SAMPLE_W-1:0]  prev_reg;
    logic                                 accept;
    logic signed [ife_pkg::SLOPE_W-2:0]   slope_prod;
    logic [ife_pkg::HSQ_W-1:0]            a2;
    logic signed [31:0]                   s2_full;
    logic [ife_pkg::HSQ_W:0]              s2;

    assign in_stall = s1_valid_reg && queue_full;
    assign accept   = in_valid && !in_stall;
    assign push     = s1_valid_reg && !queue_full;

    assign slope_prod = s1_diff_reg * $signed({1'b0, cfg.sample_rate});
    assign a2         = cfg.amplitude * cfg.amplitude;
    assign s2_full    = s1_sample_reg * s1_sample_reg;
    assign s2         = s2_full[ife_pkg::HSQ_W:0];

    always_comb
    begin
        push_item.slope        = $signed({slope_prod, 1'b0}) + ife_pkg::SLOPE_BIAS;
        push_item.out_of_range = {1'b0, a2} <= s2;
        push_item.height_sq    = a2 - s2[ife_pkg::HSQ_W-1:0];
        s1_valid_next          = accept || (s1_valid_reg && !push);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            prev_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                prev_reg <= sample;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample;
            s1_diff_reg   <= ife_pkg::DIFF_W'(sample) - ife_pkg::DIFF_W'(prev_reg);
        end
    end

endmodule

### sv/ife_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ife_queue
// short fifo between the front and the back
// ----------------------------------------------------------------------------
module ife_queue
#(
    parameter int DEPTH = ife_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ife_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output ife_pkg::item_t  pop_item,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ife_pkg::item_t      mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign pop_item = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### sv/ife_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ife_back
// square root, division, balance scaling and saturation of one item
// ----------------------------------------------------------------------------
module ife_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  ife_pkg::cfg_t                       cfg,
    input  logic                                queue_empty,
    input  ife_pkg::item_t                      pop_item,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ife_pkg::FREQ_W-1:0]   frequency,
    output logic                                out_of_range
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_MUL,
        ST_DINIT,
        ST_DIV,
        ST_SCALE,
        ST_SUM
    } state_t;

    localparam logic [47:0] MAG_CAP = 48'h8000_0000_0000;
    localparam logic [48:0] POS_MAX = 49'h0_7FFF_FFFF;
    localparam logic [48:0] NEG_MAX = 49'h0_8000_0000;

    state_t              state_reg;
    logic [5:0]          cnt_reg;
    logic                neg_reg;
    logic                oor_reg;
    logic [35:0]         mag_reg;
    logic [45:0]         sq_x_reg;
    logic [25:0]         sq_rem_reg;
    logic [22:0]         h_reg;
    logic [51:0]         m_reg;
    logic [22:0]         div_rem_reg;
    logic [47:0]         dq_reg;
    logic [47:0]         q_reg;
    logic [40:0]         p_lo_reg;
    logic [40:0]         p_hi_reg;
    logic                out_valid_reg;
    logic [31:0]         freq_reg;
    logic                oor_out_reg;

    logic [36:0]         slope_abs;
    logic [25:0]         sq_t;
    logic [25:0]         sq_trial;
    logic                sq_take;
    logic [23:0]         div_t;
    logic                div_take;
    logic [47:0]         q_capped;
    logic signed [17:0]  k;
    logic [16:0]         kabs;
    logic [64:0]         prod;
    logic [48:0]         v;
    logic [31:0]         freq_calc;
    logic                out_free;

    assign out_valid    = out_valid_reg;
    assign frequency    = freq_reg;
    assign out_of_range = oor_out_reg;
    assign out_free     = !out_valid_reg || !out_stall;
    assign pop          = (state_reg == ST_IDLE) && !queue_empty;

    always_comb
    begin
        slope_abs = pop_item.slope[36] ? 37'(-pop_item.slope) : pop_item.slope;
        sq_t      = {sq_rem_reg[23:0], sq_x_reg[45:44]};
        sq_trial  = {1'b0, h_reg, 2'b01};
        sq_take   = sq_t >= sq_trial;
        div_t     = {div_rem_reg, dq_reg[47]};
        div_take  = div_t >= {1'b0, h_reg};
        q_capped  = (q_reg > MAG_CAP) ? MAG_CAP : q_reg;
        k         = $signed({2'b01, 16'b0}) - $signed({1'b0, cfg.balance, 1'b0});
        kabs      = k[17] ? 17'(-k) : k[16:0];
        prod      = {p_hi_reg, 24'b0} + 65'(p_lo_reg);
        v         = prod[64:16];
        if (oor_reg)
        begin
            freq_calc = '0;
        end
        else if (!neg_reg)
        begin
            freq_calc = ({1'b0, q_reg} > POS_MAX) ? POS_MAX[31:0] : q_reg[31:0];
        end
        else if (k == '0)
        begin
            freq_calc = '0;
        end
        else if (!k[17])
        begin
            freq_calc = 32'd0 - ((v > NEG_MAX) ? NEG_MAX[31:0] : v[31:0]);
        end
        else
        begin
            freq_calc = (v > POS_MAX) ? POS_MAX[31:0] : v[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != ST_SUM)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!queue_empty)
                    begin
                        neg_reg    <= pop_item.slope[36];
                        mag_reg    <= slope_abs[35:0];
                        oor_reg    <= pop_item.out_of_range;
                        sq_x_reg   <= {pop_item.height_sq, 16'b0};
                        sq_rem_reg <= '0;
                        h_reg      <= '0;
                        cnt_reg    <= 6'd22;
                        state_reg  <= pop_item.out_of_range ? ST_SUM : ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    sq_x_reg   <= {sq_x_reg[43:0], 2'b00};
                    sq_rem_reg <= sq_take ? sq_t - sq_trial : sq_t;
                    h_reg      <= {h_reg[21:0], sq_take};
                    cnt_reg    <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    m_reg     <= mag_reg * cfg.speed_gain;
                    state_reg <= ST_DINIT;
                end
                ST_DINIT:
                begin
                    if ({4'b0, m_reg[51:33]} >= h_reg)
                    begin
                        q_reg     <= MAG_CAP;
                        state_reg <= ST_SCALE;
                    end
                    else
                    begin
                        div_rem_reg <= {4'b0, m_reg[51:33]};
                        dq_reg      <= {m_reg[32:0], 15'b0};
                        cnt_reg     <= 6'd47;
                        state_reg   <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    div_rem_reg <= div_take ? 23'(div_t - {1'b0, h_reg}) : div_t[22:0];
                    dq_reg      <= {dq_reg[46:0], div_take};
                    cnt_reg     <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        q_reg     <= {dq_reg[46:0], div_take};
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE:
                begin
                    q_reg     <= q_capped;
                    p_lo_reg  <= q_capped[23:0] * kabs;
                    p_hi_reg  <= q_capped[47:24] * kabs;
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        freq_reg      <= freq_calc;
                        oor_out_reg   <= oor_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && oor_out_reg |-> freq_reg == '0)
        else $error("out of range result with nonzero frequency");

    a_div_height: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> h_reg >= 23'd256)
        else $error("division started with too small a height");

    a_sqrt_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SQRT && cnt_reg == '0 |=> state_reg == ST_MUL)
        else $error("square root did not hand over to multiply");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(freq_reg))
        else $error("stalled result was overwritten");
`endif

endmodule

### sv/instantaneous_frequency_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// instantaneous_frequency_estimator
// frequency of a sine of assumed amplitude from the slope of each sample
// ----------------------------------------------------------------------------
// One sample in, one Q16.16 frequency out. A sample passes the front register
// and the queue, then the bit-pair square root, the multiply, the divider
// setup, the restoring divider, scaling and output; when the quotient
// saturates the divider is skipped, and an out of range sample goes straight
// to output. The back end works on one item at a time and takes no new item
// from the queue before the last one is through; a two-entry queue lets the
// front take samples while the back is busy.
module instantaneous_frequency_estimator
#(
    parameter int QUEUE_DEPTH = ife_pkg::QUEUE_DEPTH
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [ife_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [ife_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [ife_pkg::SAMPLE_W-1:0]   sample,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [ife_pkg::FREQ_W-1:0]     frequency,
    output logic                                  out_of_range
);

    ife_pkg::cfg_t   cfg_reg;
    ife_pkg::item_t  push_item;
    ife_pkg::item_t  pop_item;
    logic            push;
    logic            pop;
    logic            queue_full;
    logic            queue_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_rate <= ife_pkg::RATE_RESET;
            cfg_reg.amplitude   <= ife_pkg::AMP_RESET;
            cfg_reg.balance     <= ife_pkg::BAL_RESET;
            cfg_reg.speed_gain  <= ife_pkg::GAIN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ife_pkg::REG_SAMPLE_RATE: cfg_reg.sample_rate <= cfg_data;
                ife_pkg::REG_AMPLITUDE:   cfg_reg.amplitude   <= cfg_data[ife_pkg::AMP_W-1:0];
                ife_pkg::REG_BALANCE:     cfg_reg.balance     <= cfg_data[ife_pkg::BAL_W-1:0];
                ife_pkg::REG_SPEED_GAIN:  cfg_reg.speed_gain  <= cfg_data[ife_pkg::GAIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    ife_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    ife_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (queue_empty)
    );

    ife_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .queue_empty  (queue_empty),
        .pop_item     (pop_item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frequency    (frequency),
        .out_of_range (out_of_range)
    );

endmodule
